// ===== src/flrc_pkg.sv =====
`default_nettype none
package flrc_pkg;

   localparam int TABLE_DEPTH  = 64;
   localparam int ADDR_WIDTH   = 32;

   localparam int FIELD_WIDTH  = 32;
   localparam int KIND_WIDTH   = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int IDX_WIDTH    = $clog2(TABLE_DEPTH);
   localparam int CNT_WIDTH    = $clog2(TABLE_DEPTH + 1);

   localparam logic [KIND_WIDTH-1:0] KIND_APPEND  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_LIST    = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ENTRY = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] start;
      logic [ADDR_WIDTH-1:0] size;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } slot_ctl_type;

   // saturating add of two sizes
   function automatic logic [ADDR_WIDTH-1:0] sat_add(input logic [ADDR_WIDTH-1:0] a,
                                                      input logic [ADDR_WIDTH-1:0] b);
      logic [ADDR_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum[ADDR_WIDTH]) begin
         return {ADDR_WIDTH{1'b1}};
      end
      return sum[ADDR_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/flrc_req_if.sv =====
`default_nettype none
interface flrc_req_if;
   logic                          valid;
   logic                          ready;
   logic [flrc_pkg::KIND_WIDTH-1:0]  kind;
   logic [flrc_pkg::FIELD_WIDTH-1:0] block_start;
   logic [flrc_pkg::FIELD_WIDTH-1:0] block_size;

   modport source (output valid, kind, block_start, block_size, input ready);
   modport sink   (input valid, kind, block_start, block_size, output ready);
endinterface
`default_nettype wire

// ===== src/flrc_rsp_if.sv =====
`default_nettype none
interface flrc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [flrc_pkg::STATUS_WIDTH-1:0] status;
   logic [flrc_pkg::FIELD_WIDTH-1:0]  entry_start;
   logic [flrc_pkg::FIELD_WIDTH-1:0]  entry_size;
   logic                            last;

   modport source (output valid, status, entry_start, entry_size, last, input ready);
   modport sink   (input valid, status, entry_start, entry_size, last, output ready);
endinterface
`default_nettype wire

// ===== src/flrc_slot.sv =====
`default_nettype none
module flrc_slot (
   input  wire                      clock,
   input  flrc_pkg::slot_ctl_type   ctl,
   input  flrc_pkg::entry_type      shift_in,
   input  flrc_pkg::entry_type      load_data,
   output flrc_pkg::entry_type      q
);
   import flrc_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // take the neighbour's entry on a shift, a fresh one on a direct load
   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = shift_in;
      end else if (ctl.load) begin
         entry_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule
`default_nettype wire

// ===== src/free_list_release_coalescer.sv =====
`default_nettype none
// Free-list release coalescer.
// Keeps an address-ordered table of free blocks (start, size) in a ring of
// slot cells. Transactions arrive on req_ch (kind, block_start, block_size):
// kind 0 appends a block at the end of the table, kind 1 releases a block and
// merges it with its left and/or right neighbour or inserts it in order,
// kind 2 lists the table. Results leave on rsp_ch (status, entry_start,
// entry_size, last); last marks the final result of each transaction.
// Steps: an append or an unknown kind goes straight to the final result. A
// release that merges turns the ring once to find the neighbours and the
// insert point, forms the merged size in the CALC1 and CALC2 states, turns
// the ring once more to rewrite the table, and then hands over the result.
// An insertion forms the size in CALC1 alone, and a release dropped on a full
// table skips the second turn. The ring turns one slot per cycle unless a
// listing stall holds it. A listing turns the ring once and hands over each
// entry below the count.
// req_ch.ready is high whenever no transaction is being worked on, also while
// a result still waits in the output register. A stall on rsp_ch holds the
// ring (listing) or the sequencer (final result); nothing is lost.
// Reset clears the entry count, the sequencer and the output register; the
// slot contents need no clearing, as only slots below the count are read.
module free_list_release_coalescer (
   input wire          clock,
   input wire          reset,
   flrc_req_if.sink    req_ch,
   flrc_rsp_if.source  rsp_ch
);
   import flrc_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_CALC1   = 3'd2;
   localparam logic [2:0] ST_CALC2   = 3'd3;
   localparam logic [2:0] ST_REBUILD = 3'd4;
   localparam logic [2:0] ST_LIST    = 3'd5;
   localparam logic [2:0] ST_FINISH  = 3'd6;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_MERGE  = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [IDX_WIDTH-1:0] LAST_STEP = IDX_WIDTH'(TABLE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(TABLE_DEPTH);

   // control registers
   logic [2:0]            state_ff, state_in;
   logic [IDX_WIDTH-1:0]  step_ff, step_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  has_l_ff, has_l_in;
   logic                  has_r_ff, has_r_in;
   logic                  pos_found_ff, pos_found_in;
   logic [1:0]            mode_ff, mode_in;

   // payload registers
   logic [ADDR_WIDTH-1:0]   start_ff, start_in;
   logic [ADDR_WIDTH-1:0]   size_ff, size_in;
   logic [ADDR_WIDTH:0]     end_ff, end_in;
   logic [IDX_WIDTH-1:0]    l_ff, l_in;
   logic [IDX_WIDTH-1:0]    r_ff, r_in;
   logic [IDX_WIDTH-1:0]    pos_ff, pos_in;
   logic [ADDR_WIDTH-1:0]   start_l_ff, start_l_in;
   logic [ADDR_WIDTH-1:0]   size_l_ff, size_l_in;
   logic [ADDR_WIDTH-1:0]   size_r_ff, size_r_in;
   logic [IDX_WIDTH-1:0]    m_idx_ff, m_idx_in;
   logic [ADDR_WIDTH-1:0]   m_start_ff, m_start_in;
   logic [ADDR_WIDTH-1:0]   m_size_ff, m_size_in;
   entry_type               hold_ff, hold_in;
   logic [STATUS_WIDTH-1:0] fin_status_ff, fin_status_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_WIDTH-1:0]   rsp_start_ff, rsp_start_in;
   logic [ADDR_WIDTH-1:0]   rsp_size_ff, rsp_size_in;
   logic                    rsp_last_ff, rsp_last_in;

   // ring of slots
   entry_type    slot_q [TABLE_DEPTH];
   entry_type    push_data;
   entry_type    append_data;
   logic         ring_shift;
   logic         append_we;

   // datapath helpers
   entry_type            head;
   entry_type            nxt;
   entry_type            src;
   logic [ADDR_WIDTH:0]  head_end;
   logic [IDX_WIDTH:0]   src_idx;
   logic                 del_after;
   logic                 in_range;
   logic                 out_free;
   logic                 out_load;
   logic                 req_take;
   logic                 eff_r;
   logic [ADDR_WIDTH-1:0] part_size;
   logic [ADDR_WIDTH-1:0] req_start;
   logic [ADDR_WIDTH-1:0] req_size;

   assign head      = slot_q[0];
   assign nxt       = slot_q[1];
   assign head_end  = {1'b0, head.start} + {1'b0, head.size};
   assign in_range  = CNT_WIDTH'(step_ff) < count_ff;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_take  = req_ch.valid && req_ch.ready;
   assign req_start = req_ch.block_start[ADDR_WIDTH-1:0];
   assign req_size  = req_ch.block_size[ADDR_WIDTH-1:0];
   assign append_data.start = req_start;
   assign append_data.size  = req_size;
   assign append_we = req_take && (req_ch.kind == KIND_APPEND) && (count_ff < FULL_COUNT);

   // a block that matches the same entry on both sides merges left only
   assign eff_r     = has_r_ff && !(has_l_ff && (l_ff == r_ff));
   assign part_size = sat_add(has_l_ff ? size_l_ff : size_r_ff, size_ff);

   // after the removed entry, each place takes its right-hand neighbour
   assign del_after = (mode_ff == MODE_DELETE) && (step_ff >= r_ff);
   assign src       = del_after ? nxt : head;
   assign src_idx   = {1'b0, step_ff} + {{IDX_WIDTH{1'b0}}, del_after};

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      has_l_in      = has_l_ff;
      has_r_in      = has_r_ff;
      pos_found_in  = pos_found_ff;
      mode_in       = mode_ff;
      start_in      = start_ff;
      size_in       = size_ff;
      end_in        = end_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      pos_in        = pos_ff;
      start_l_in    = start_l_ff;
      size_l_in     = size_l_ff;
      size_r_in     = size_r_ff;
      m_idx_in      = m_idx_ff;
      m_start_in    = m_start_ff;
      m_size_in     = m_size_ff;
      hold_in       = hold_ff;
      fin_status_in = fin_status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_last_in   = rsp_last_ff;
      ring_shift    = 1'b0;
      push_data     = head;
      out_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               start_in      = req_start;
               size_in       = req_size;
               end_in        = {1'b0, req_start} + {1'b0, req_size};
               step_in       = '0;
               fin_status_in = STATUS_DONE;
               case (req_ch.kind)
                  KIND_APPEND: begin
                     if (count_ff < FULL_COUNT) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        fin_status_in = STATUS_FULL;
                     end
                     state_in = ST_FINISH;
                  end
                  KIND_RELEASE: begin
                     has_l_in     = 1'b0;
                     has_r_in     = 1'b0;
                     pos_found_in = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  KIND_LIST: begin
                     if (count_ff == '0) begin
                        fin_status_in = STATUS_EMPTY;
                        state_in      = ST_FINISH;
                     end else begin
                        state_in = ST_LIST;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // turn the ring once, watching the head slot; later neighbour hits win, the first insert point stays
            ring_shift = 1'b1;
            push_data  = head;
            if (in_range) begin
               if ({1'b0, head.start} == end_ff) begin
                  has_r_in  = 1'b1;
                  r_in      = step_ff;
                  size_r_in = head.size;
               end
               if (head_end == {1'b0, start_ff}) begin
                  has_l_in   = 1'b1;
                  l_in       = step_ff;
                  start_l_in = head.start;
                  size_l_in  = head.size;
               end
               if (!pos_found_ff && (head_end >= {1'b0, start_ff})) begin
                  pos_found_in = 1'b1;
                  pos_in       = step_ff;
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_CALC1;
            end
         end

         ST_CALC1: begin
            has_r_in = eff_r;
            if (!has_l_ff && !eff_r) begin
               if (count_ff == FULL_COUNT) begin
                  fin_status_in = STATUS_FULL;
                  state_in      = ST_FINISH;
               end else begin
                  mode_in  = MODE_INSERT;
                  if (!pos_found_ff) begin
                     pos_in = count_ff[IDX_WIDTH-1:0];
                  end
                  step_in  = '0;
                  state_in = ST_REBUILD;
               end
            end else begin
               m_size_in  = part_size;
               m_idx_in   = has_l_ff ? l_ff : r_ff;
               m_start_in = has_l_ff ? start_l_ff : start_ff;
               mode_in    = (has_l_ff && eff_r) ? MODE_DELETE : MODE_MERGE;
               state_in   = ST_CALC2;
            end
         end

         ST_CALC2: begin
            if (mode_ff == MODE_DELETE) begin
               m_size_in = sat_add(m_size_ff, size_r_ff);
            end
            step_in  = '0;
            state_in = ST_REBUILD;
         end

         ST_REBUILD: begin
            // second turn of the ring, rewriting the table as it passes
            ring_shift = 1'b1;
            if (mode_ff == MODE_INSERT) begin
               if (step_ff < pos_ff) begin
                  push_data = head;
               end else if (step_ff == pos_ff) begin
                  push_data.start = start_ff;
                  push_data.size  = size_ff;
                  hold_in         = head;
               end else begin
                  push_data = hold_ff;
                  hold_in   = head;
               end
            end else begin
               push_data = src;
               if (src_idx == {1'b0, m_idx_ff}) begin
                  push_data.start = m_start_ff;
                  push_data.size  = m_size_ff;
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in = '0;
               case (mode_ff)
                  MODE_INSERT: count_in = count_ff + 1'b1;
                  MODE_DELETE: count_in = count_ff - 1'b1;
                  default:     count_in = count_ff;
               endcase
               fin_status_in = STATUS_DONE;
               state_in      = ST_FINISH;
            end
         end

         ST_LIST: begin
            // hold the ring while a listed entry cannot be handed over
            if (!in_range || out_free) begin
               ring_shift = 1'b1;
               push_data  = head;
               if (in_range) begin
                  out_load      = 1'b1;
                  rsp_status_in = STATUS_ENTRY;
                  rsp_start_in  = head.start;
                  rsp_size_in   = head.size;
                  rsp_last_in   = (CNT_WIDTH'(step_ff) + 1'b1) == count_ff;
               end
               step_in = step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  step_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = fin_status_ff;
               rsp_start_in  = '0;
               rsp_size_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         has_l_ff     <= 1'b0;
         has_r_ff     <= 1'b0;
         pos_found_ff <= 1'b0;
         mode_ff      <= MODE_INSERT;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         has_l_ff     <= has_l_in;
         has_r_ff     <= has_r_in;
         pos_found_ff <= pos_found_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      size_ff       <= size_in;
      end_ff        <= end_in;
      l_ff          <= l_in;
      r_ff          <= r_in;
      pos_ff        <= pos_in;
      start_l_ff    <= start_l_in;
      size_l_ff     <= size_l_in;
      size_r_ff     <= size_r_in;
      m_idx_ff      <= m_idx_in;
      m_start_ff    <= m_start_in;
      m_size_ff     <= m_size_in;
      hold_ff       <= hold_in;
      fin_status_ff <= fin_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // row of slots: on a shift each takes its right-hand neighbour, the tail the push value
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_slot
      slot_ctl_type ctl;
      entry_type    shift_in;

      assign ctl.shift = ring_shift;
      assign ctl.load  = append_we && (count_ff[IDX_WIDTH-1:0] == IDX_WIDTH'(k));

      if (k == TABLE_DEPTH - 1) begin : g_tail
         assign shift_in = push_data;
      end else begin : g_body
         assign shift_in = slot_q[k+1];
      end

      flrc_slot u_slot (
         .clock     (clock),
         .ctl       (ctl),
         .shift_in  (shift_in),
         .load_data (append_data),
         .q         (slot_q[k])
      );
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_start = FIELD_WIDTH'(rsp_start_ff);
   assign rsp_ch.entry_size  = FIELD_WIDTH'(rsp_size_ff);
   assign rsp_ch.last        = rsp_last_ff;

   // the table never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table depth");

   // an insertion pass grows the table by exactly one entry
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REBUILD && step_ff == LAST_STEP && mode_ff == MODE_INSERT)
      |=> (count_ff == CNT_WIDTH'($past(count_ff) + 1'b1)))
      else $error("insertion did not add one entry");

   // a two-sided merge never names the same entry on both sides
   a_distinct_sides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC2 && mode_ff == MODE_DELETE) |-> (l_ff != r_ff))
      else $error("two-sided merge on a single entry");

   // an insertion only starts from a table that is not full
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REBUILD && mode_ff == MODE_INSERT) |-> (count_ff < FULL_COUNT))
      else $error("insertion into a full table");

   // listed entries come only from the valid part of the table
   a_list_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIST && out_load) |-> in_range)
      else $error("listing beyond the entry count");

endmodule
`default_nettype wire
